[rtl/pcx_rle_line_encoder_macros.svh]
// Assertion macros shared by the PCX run-length encoder RTL.
`ifndef PCX_RLE_LINE_ENCODER_MACROS_SVH
`define PCX_RLE_LINE_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define PCX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond must never be true outside reset
`define PCX_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PCX_ASSERT(label, clk, rst, prop, msg)
`define PCX_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[rtl/pcx_rle_pkg.sv]
// Types and constants of the PCX run-length line encoder.
`timescale 1ns / 1ps

package pcx_rle_pkg;

  localparam int RUN_W         = 6;
  localparam int MAX_RUN_DEF   = 63;
  localparam int CMD_DEPTH_DEF = 4;

  // top two bits set mark a count byte
  localparam logic [1:0] ESC_MARK = 2'b11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       line_done;
  } result_t;

  // one run to be written out
  typedef struct packed {
    logic             valid;
    logic [7:0]       value;
    logic [RUN_W-1:0] len;
  } run_t;

  // work for the back end: closed run, flushed run at line end
  typedef struct packed {
    run_t closed;
    run_t flushed;
    logic line_end;
  } cmd_t;

endpackage

[rtl/pcx_rle_front.sv]
// Front end: accepts bytes, tracks the held run, emits run commands.
`timescale 1ns / 1ps

module pcx_rle_front #(
  parameter int MAX_RUN = pcx_rle_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  pcx_rle_pkg::item_t             item,
  output logic                           cmd_push,
  output pcx_rle_pkg::cmd_t              cmd,
  output logic [pcx_rle_pkg::RUN_W-1:0]  held_len
);

  localparam logic [pcx_rle_pkg::RUN_W-1:0] MAX_LEN = pcx_rle_pkg::RUN_W'(MAX_RUN);
  localparam logic [pcx_rle_pkg::RUN_W-1:0] ONE     = pcx_rle_pkg::RUN_W'(1);

  logic [7:0]                    held_value;
  logic [7:0]                    held_value_next;
  logic [pcx_rle_pkg::RUN_W-1:0] run_length;
  logic [pcx_rle_pkg::RUN_W-1:0] run_length_next;
  logic                          extend;

  assign extend = (run_length != '0) && (item.data_byte == held_value) &&
                  (run_length < MAX_LEN);

  always_comb begin
    cmd.closed.valid  = 1'b0;
    cmd.closed.value  = held_value;
    cmd.closed.len    = run_length;
    held_value_next   = held_value;
    run_length_next   = run_length;
    if (extend) begin
      run_length_next = run_length + ONE;
    end else begin
      cmd.closed.valid = (run_length != '0);
      held_value_next  = item.data_byte;
      run_length_next  = ONE;
    end
    cmd.flushed.valid = item.line_end;
    cmd.flushed.value = held_value_next;
    cmd.flushed.len   = run_length_next;
    cmd.line_end      = item.line_end;
    if (item.line_end) begin
      run_length_next = '0;
    end
  end

  assign cmd_push = take && (cmd.closed.valid || cmd.flushed.valid);
  assign held_len = run_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= '0;
      run_length <= '0;
    end else if (take) begin
      held_value <= held_value_next;
      run_length <= run_length_next;
    end
  end

endmodule

[rtl/pcx_rle_cmd_fifo.sv]
// Short command queue between front and back end.
`timescale 1ns / 1ps

module pcx_rle_cmd_fifo #(
  parameter int DEPTH = pcx_rle_pkg::CMD_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  pcx_rle_pkg::cmd_t wdata,
  input  logic              rd,
  output pcx_rle_pkg::cmd_t rdata,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pcx_rle_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/pcx_rle_back.sv]
// Back end: expands run commands, one code byte per unstalled cycle.
`timescale 1ns / 1ps

module pcx_rle_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  pcx_rle_pkg::cmd_t     cmd,
  output logic                  cmd_pop,
  input  logic                  pop,
  output logic                  empty,
  output pcx_rle_pkg::result_t  result
);

  logic              on_flushed;  // second run of the command in progress
  logic              count_sent;  // count byte of current run already out
  logic              out_valid;
  logic              use_flushed;
  pcx_rle_pkg::run_t run;
  logic              escaped;
  logic              run_done;
  logic              cmd_done;
  logic              emit;
  logic [7:0]        byte_out;

  assign use_flushed = on_flushed || !cmd.closed.valid;
  assign run         = use_flushed ? cmd.flushed : cmd.closed;
  assign escaped     = (run.len != pcx_rle_pkg::RUN_W'(1)) ||
                       (run.value[7:6] == pcx_rle_pkg::ESC_MARK);
  assign byte_out    = (escaped && !count_sent) ? {pcx_rle_pkg::ESC_MARK, run.len} : run.value;
  assign run_done    = !escaped || count_sent;
  assign cmd_done    = run_done && (use_flushed || !cmd.flushed.valid);
  assign emit        = !cmd_empty && (!out_valid || pop);
  assign cmd_pop     = emit && cmd_done;
  assign empty       = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      on_flushed <= 1'b0;
      count_sent <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (cmd_done) begin
          on_flushed <= 1'b0;
          count_sent <= 1'b0;
        end else if (run_done) begin
          on_flushed <= 1'b1;
          count_sent <= 1'b0;
        end else begin
          count_sent <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.code_byte    <= byte_out;
      result.last_of_item <= cmd_done;
      result.line_done    <= cmd_done && cmd.line_end;
    end
  end

endmodule

[rtl/pcx_rle_line_encoder.sv]
// Top level of the PCX run-length line encoder.
//
//   channel  dir  handshake             payload
//   item     in   push / full           pcx_rle_pkg::item_t   (data_byte, line_end)
//   result   out  pop / empty           pcx_rle_pkg::result_t (code_byte, last_of_item,
//                                                              line_done)
//
// The front end takes one byte per cycle while the command queue has room; a
// byte that only extends the held run costs nothing downstream.
// The back end writes one code byte per cycle while the output is popped; an input
// beat yields 0 to 4 code bytes (2 for an escaped literal); the back end's single
// byte-per-cycle expander sets the sustained rate.
// The first code byte of an accepted closing byte passes through the command queue
// and then the result register before it reaches the result ports.
// rst is synchronous, active high; it drops the held run, the queue and the
// output register. A stalled output only stalls the input once the queue fills.
`timescale 1ns / 1ps
`include "pcx_rle_line_encoder_macros.svh"

module pcx_rle_line_encoder #(
  parameter int MAX_RUN   = pcx_rle_pkg::MAX_RUN_DEF,   // 1 .. 63
  parameter int CMD_DEPTH = pcx_rle_pkg::CMD_DEPTH_DEF  // 2 or more
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pcx_rle_pkg::item_t   item,
  output logic                 empty,
  input  logic                 pop,
  output pcx_rle_pkg::result_t result
);

  logic                          take;
  logic                          cmd_push;
  logic                          cmd_pop;
  logic                          cmd_full;
  logic                          cmd_empty;
  pcx_rle_pkg::cmd_t             cmd_in;
  pcx_rle_pkg::cmd_t             cmd_head;
  logic [pcx_rle_pkg::RUN_W-1:0] held_len;

  // input beat is taken whenever the queue can hold its command
  assign full = cmd_full;
  assign take = push && !cmd_full;

  pcx_rle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .held_len (held_len)
  );

  pcx_rle_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .rd    (cmd_pop),
    .rdata (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  pcx_rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // a line end always leaves the front end with no run held
  `PCX_ASSERT(a_line_end_clears, clk, rst, (take && item.line_end) |=> (held_len == '0), "run held past line end")
  // the held run never exceeds the configured limit
  `PCX_ASSERT_NEVER(a_run_limit, clk, rst, held_len > pcx_rle_pkg::RUN_W'(MAX_RUN), "run over limit")
  // end of line only on the last beat of an item
  `PCX_ASSERT_NEVER(a_line_done_last, clk, rst, !empty && result.line_done && !result.last_of_item, "line_done without last_of_item")
  // back end only retires a command that is present
  `PCX_ASSERT_NEVER(a_pop_on_empty, clk, rst, cmd_pop && cmd_empty, "command popped from empty queue")

endmodule

[tb/tb_pcx_rle_line_encoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the PCX run-length line encoder.

module tb_pcx_rle_line_encoder;

  localparam int         MAX_RUN      = pcx_rle_pkg::MAX_RUN_DEF;
  localparam logic [7:0] COUNT_TAG    = 8'hC0;  // OR'd with the run length
  localparam int         RANDOM_BEATS = 450;
  localparam int         STALL_LIMIT  = 5000;   // cycles with no beat on either side
  localparam int         TAIL_CYCLES  = 20;     // quiet time after the last code byte

  // one pending input beat; drain_first holds it back until all codes are out
  typedef struct {
    pcx_rle_pkg::item_t beat;
    bit                 drain_first;
  } send_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  pcx_rle_pkg::item_t   item;
  logic                 empty;
  logic                 pop;
  pcx_rle_pkg::result_t result;

  send_t                to_send[$];         // beats not yet accepted, front is on the bus
  pcx_rle_pkg::result_t expected_codes[$];  // code bytes predicted, oldest first
  pcx_rle_pkg::result_t beat_codes[$];      // scratch: codes caused by the current beat

  // predictor state: the run being gathered
  logic [7:0] held_val;
  logic [5:0] held_len;

  bit drain_next;
  bit all_codes_in;
  int idle_phase;
  int total_beats;
  int beats_in;
  int codes_out;
  int lines_in;
  int full_runs;
  int errors;
  int stall_cycles;

  pcx_rle_line_encoder DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_beat(input logic [7:0] b, input logic le);
    send_t s;
    s.beat.data_byte = b;
    s.beat.line_end  = le;
    s.drain_first    = drain_next;
    drain_next       = 1'b0;
    to_send.push_back(s);
  endfunction

  // n equal bytes; only the last one may end the line
  function automatic void add_run(input logic [7:0] v, input int n, input bit end_line);
    for (int i = 0; i < n; i++)
      add_beat(v, end_line && (i == n - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Encoder prediction
  // ---------------------------------------------------------------------------
  function automatic void emit_code(input logic [7:0] c);
    pcx_rle_pkg::result_t r;
    r.code_byte    = c;
    r.last_of_item = 1'b0;
    r.line_done    = 1'b0;
    beat_codes.push_back(r);
  endfunction

  // Write out the held run: a count/value pair for a real run or for a lone
  // byte that would look like a count byte, else the bare byte.
  function automatic void close_run();
    if (held_len != 0) begin
      if (held_len == MAX_RUN) full_runs++;
      if (held_len > 1 || held_val[7:6] == pcx_rle_pkg::ESC_MARK) begin
        emit_code(COUNT_TAG | {2'b00, held_len});
        emit_code(held_val);
      end else begin
        emit_code(held_val);
      end
      held_len = '0;
    end
  endfunction

  function automatic void encode_beat(input pcx_rle_pkg::item_t it);
    pcx_rle_pkg::result_t r;
    beat_codes.delete();
    // an equal byte grows the run unless it is already full
    if (held_len != 0 && it.data_byte == held_val && held_len < MAX_RUN) begin
      held_len = held_len + 1'b1;
    end else begin
      close_run();
      held_val = it.data_byte;
      held_len = 6'd1;
    end
    // runs never cross a line end
    if (it.line_end) close_run();
    if (beat_codes.size() > 0) begin
      r              = beat_codes[beat_codes.size() - 1];
      r.last_of_item = 1'b1;
      r.line_done    = it.line_end;
      beat_codes[beat_codes.size() - 1] = r;
    end
    foreach (beat_codes[i]) expected_codes.push_back(beat_codes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the front of to_send, idles at random per phase.
  // Phase 0: sender idles 7%, phase 1: 84%, afterwards never.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit took;
    bit go;
    took = 1'b0;
    go   = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        void'(to_send.pop_front());
        took = 1'b1;
      end
      if (to_send.size() != 0) begin
        // a drain point waits for a fresh view of the expected queue
        if (to_send[0].drain_first && (took || !all_codes_in))
          go = 1'b0;
        else
          go = $urandom_range(0, 99) >= (idle_phase == 0 ? 7 : idle_phase == 1 ? 84 : 0);
        if (go) item <= to_send[0].beat;
      end
    end
    push <= go;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every input beat, checks every output beat.
  // Receiver idles 84% in phase 0, 7% in phase 1, never afterwards.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pcx_rle_pkg::result_t want;
    if (rst) begin
      held_val = '0;
      held_len = '0;
      pop <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_beat(item);
        beats_in++;
        if (item.line_end) lines_in++;
      end
      if (pop && !empty) begin
        codes_out++;
        if (expected_codes.size() == 0) begin
          errors++;
          $display("%0t: code %h last_of_item %b line_done %b with nothing expected",
                   $time, result.code_byte, result.last_of_item, result.line_done);
        end else begin
          want = expected_codes.pop_front();
          if (result.code_byte !== want.code_byte ||
              result.last_of_item !== want.last_of_item ||
              result.line_done !== want.line_done) begin
            errors++;
            $display("%0t: expected code %h last %b done %b, got code %h last %b done %b",
                     $time, want.code_byte, want.last_of_item, want.line_done,
                     result.code_byte, result.last_of_item, result.line_done);
          end
        end
      end
      idle_phase   <= (beats_in * 3) / total_beats;
      all_codes_in <= (expected_codes.size() == 0);
      pop <= $urandom_range(0, 99) >= (idle_phase == 0 ? 84 : idle_phase == 1 ? 7 : 0);
    end
  end

  // Watchdog: too long without a beat on either side ends the run.
  always @(posedge clk) begin : watchdog
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d codes still expected",
               $time, stall_cycles, expected_codes.size());
      $display("pcx_rle_line_encoder: mismatch");
      $finish;
    end else if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         line_len;
    int         n;
    int         directed;
    bit         mid_drained;
    logic [7:0] v;
    send_t      s;

    clk          = 1'b0;
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    item         = '0;
    held_val     = '0;
    held_len     = '0;
    drain_next   = 1'b0;
    all_codes_in = 1'b1;
    idle_phase   = 0;
    beats_in     = 0;
    codes_out    = 0;
    lines_in     = 0;
    full_runs    = 0;
    errors       = 0;
    stall_cycles = 0;
    mid_drained  = 1'b0;

    // Directed: one-byte lines (plain, escaped, extremes)
    add_beat(8'h00, 1'b1);
    add_beat(8'hC0, 1'b1);
    add_beat(8'hFF, 1'b1);
    add_beat(8'hBF, 1'b1);
    // run of two that ends the line on an extending byte
    add_run(8'h7F, 2, 1'b1);
    // runs closed mid-line, escaped lone byte mid-line
    add_beat(8'h12, 1'b0);
    add_run(8'h34, 3, 1'b0);
    add_beat(8'hE5, 1'b0);
    add_beat(8'h01, 1'b1);
    // closing run plus escaped flush on the same beat: four codes
    add_run(8'h80, 2, 1'b0);
    add_beat(8'hEE, 1'b1);
    // same value across a line boundary must start a new run
    add_run(8'h00, 3, 1'b1);
    add_beat(8'h00, 1'b1);
    directed = to_send.size();

    // Random: pause for a full drain first, then one run past the full length
    drain_next = 1'b1;
    add_run(8'($urandom_range(0, 255)), $urandom_range(MAX_RUN + 1, 2 * MAX_RUN + 1), 1'b1);
    while (to_send.size() < directed + RANDOM_BEATS) begin
      if (!mid_drained && to_send.size() >= directed + RANDOM_BEATS / 2) begin
        drain_next  = 1'b1;
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        // well-formed line built from runs
        line_len = $urandom_range(1, 40);
        while (line_len > 0) begin
          v = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(192, 255))
                                           : 8'($urandom_range(0, 255));
          n = $urandom_range(0, 99);
          if (n < 60)      n = 1;
          else if (n < 85) n = $urandom_range(2, 4);
          else if (n < 95) n = $urandom_range(5, 20);
          else             n = $urandom_range(MAX_RUN - 3, 2 * MAX_RUN + 4);
          if (n > line_len) n = line_len;
          line_len -= n;
          add_run(v, n, line_len == 0);
        end
      end else begin
        // noise: random bytes with random line ends
        repeat ($urandom_range(1, 8))
          add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    // close the last line so no run is left held
    s = to_send[to_send.size() - 1];
    s.beat.line_end = 1'b1;
    to_send[to_send.size() - 1] = s;
    total_beats = to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (to_send.size() != 0 || expected_codes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input beats over %0d lines, %0d code bytes checked",
             beats_in, lines_in, codes_out);
    $display("%0d full-length runs closed, %0d errors", full_runs, errors);
    if (errors == 0) begin
      $display("pcx_rle_line_encoder: match");
    end else begin
      $display("pcx_rle_line_encoder: mismatch");
    end
    $finish;
  end

endmodule
